@@ design/slacm_pkg.sv @@
`default_nettype none

package slacm_pkg;

	// Default sizes for the top level parameters.
	localparam int unsigned DEF_MAX_SET_BITS = 10;
	localparam int unsigned DEF_MAX_WAYS     = 8;
	localparam int unsigned DEF_ADDR_WIDTH   = 48;
	localparam int unsigned DEF_AGE_WIDTH    = 32;

	// Fixed field widths.
	localparam int unsigned OP_W          = 2;
	localparam int unsigned WAY_FIELD_W   = 3;
	localparam int unsigned TOTAL_W       = 32;
	localparam int unsigned SET_BITS_W    = 4;
	localparam int unsigned BLOCK_BITS_W  = 5;
	localparam int unsigned WAYS_W        = 4;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 5;

	// Access codes.
	localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

	// Control from the sequencer to the way scan unit.
	typedef struct packed {
		logic start;
		logic step;
		logic line_valid;
	} scan_ctl_t;

	// Status from the way scan unit back to the sequencer.
	typedef struct packed {
		logic hit;
		logic have_invalid;
	} scan_res_t;

	// Saturating increment of a running total.
	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] x);
		return (x == '1) ? x : x + 1'b1;
	endfunction

endpackage

`default_nettype wire

@@ design/slacm_if.sv @@
`default_nettype none

// Access request channel.
interface slacm_req_if #(
	parameter int unsigned ADDR_WIDTH = slacm_pkg::DEF_ADDR_WIDTH
);
	import slacm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       op;
	logic [ADDR_WIDTH-1:0] address;

	modport source (output valid, output op, output address, input ready);
	modport sink   (input valid, input op, input address, output ready);
endinterface

// Access result channel.
interface slacm_rsp_if;
	import slacm_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic                   evicted;
	logic [WAY_FIELD_W-1:0] way;
	logic [TOTAL_W-1:0]     hit_total;
	logic [TOTAL_W-1:0]     miss_total;
	logic [TOTAL_W-1:0]     eviction_total;
	logic                   last;

	modport source (output valid, output hit, output evicted, output way, output hit_total,
		output miss_total, output eviction_total, output last, input ready);
	modport sink   (input valid, input hit, input evicted, input way, input hit_total,
		input miss_total, input eviction_total, input last, output ready);
endinterface

`default_nettype wire

@@ design/slacm_ram.sv @@
`default_nettype none

// Simple dual port RAM: one write port, one read port with registered data.
module slacm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ design/slacm_scan.sv @@
`default_nettype none

// Way scan unit: takes one way of the set per step and keeps the first
// matching way, and the lowest invalid way or else the oldest valid way.
module slacm_scan #(
	parameter int unsigned ADDR_WIDTH = slacm_pkg::DEF_ADDR_WIDTH,
	parameter int unsigned AGE_WIDTH  = slacm_pkg::DEF_AGE_WIDTH,
	parameter int unsigned MAX_WAYS   = slacm_pkg::DEF_MAX_WAYS,
	localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire slacm_pkg::scan_ctl_t  ctl,
	input  wire logic [WAY_W-1:0]      way,
	input  wire logic [ADDR_WIDTH-1:0] want_tag,
	input  wire logic [ADDR_WIDTH-1:0] line_tag,
	input  wire logic [AGE_WIDTH-1:0]  line_age,
	output slacm_pkg::scan_res_t       res,
	output logic      [WAY_W-1:0]      chosen
);
	import slacm_pkg::*;

	logic                 hit_q;
	logic [WAY_W-1:0]     hit_way_q;
	logic                 inv_q;
	logic [WAY_W-1:0]     pick_q;
	logic [AGE_WIDTH-1:0] oldest_q;
	logic                 match;

	// A stored tag counts only when its line is valid.
	assign match = ctl.line_valid && (line_tag == want_tag);

	// Running search state over the ways of the set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			hit_way_q <= '0;
			inv_q     <= 1'b0;
			pick_q    <= '0;
			oldest_q  <= '0;
		end else if (ctl.start) begin
			hit_q     <= 1'b0;
			hit_way_q <= '0;
			inv_q     <= 1'b0;
			pick_q    <= '0;
			oldest_q  <= '0;
		end else if (ctl.step) begin
			if (match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_way_q <= way;
			end
			if (!ctl.line_valid) begin
				if (!inv_q) begin
					inv_q  <= 1'b1;
					pick_q <= way;
				end
			end else if (!inv_q && (line_age >= oldest_q)) begin
				// Ties go to the higher way, as it comes later.
				oldest_q <= line_age;
				pick_q   <= way;
			end
		end
	end

	assign res.hit          = hit_q;
	assign res.have_invalid = inv_q;
	assign chosen           = hit_q ? hit_way_q : pick_q;

endmodule

`default_nettype wire

@@ design/set_assoc_lru_cache_model_top.sv @@
`default_nettype none

// Set-associative cache model with LRU ages, counting hits, misses and
// evictions. Each accepted item is a load, a store or a modify; a modify
// runs two accesses and gives two results, the second marked last, and
// the unused op code gives no result. One access of W ways in use runs
// these steps from acceptance to its result: a set address step, a scan
// that reads one way's tag and age per cycle through a single way
// compare unit, a decision step that writes the tag and valid row on a
// miss, an age writeback of one way per cycle and a done step that loads
// the result register once that register is free. A modify runs the
// steps twice. After reset the valid memory is cleared one set per cycle,
// during which no item is accepted; configuration writes belong to
// times when no item is in flight and do not flush the cache.
module set_assoc_lru_cache_model_top #(
	parameter int unsigned MAX_SET_BITS = slacm_pkg::DEF_MAX_SET_BITS,
	parameter int unsigned MAX_WAYS     = slacm_pkg::DEF_MAX_WAYS,
	parameter int unsigned ADDR_WIDTH   = slacm_pkg::DEF_ADDR_WIDTH,
	parameter int unsigned AGE_WIDTH    = slacm_pkg::DEF_AGE_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [slacm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [slacm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	slacm_req_if.sink                             req,
	slacm_rsp_if.source                           rsp
);
	import slacm_pkg::*;

	localparam int unsigned SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int unsigned NUM_SETS  = 1 << MAX_SET_BITS;
	localparam int unsigned NUM_LINES = NUM_SETS * MAX_WAYS;
	localparam int unsigned LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int unsigned WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned CNT_W     = $clog2(MAX_WAYS + 1);
	localparam int unsigned SHIFT_W   = $clog2(MAX_SET_BITS + (1 << BLOCK_BITS_W));
	localparam logic [AGE_WIDTH-1:0] AGE_MAX   = '1;
	localparam logic [LINE_W-1:0]    WAYS_LINE = LINE_W'(MAX_WAYS);
	localparam logic [SET_W-1:0]     LAST_SET  = SET_W'(NUM_SETS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_SCAN,
		ST_DECIDE,
		ST_AGE,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [SET_BITS_W-1:0]   set_bits_q;
	logic [BLOCK_BITS_W-1:0] block_bits_q;
	logic [WAYS_W-1:0]       ways_in_use_q;

	// Item and access registers.
	logic [OP_W-1:0]       op_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [SET_W-1:0]      set_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic [LINE_W-1:0]     base_q;
	logic [CNT_W-1:0]      ways_q;
	logic                  second_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SET_W-1:0]      clr_cnt_q;
	logic [WAY_W-1:0]      keep_q;
	logic [MAX_WAYS-1:0]   vrow_q;
	logic                  hit_res_q;
	logic                  evict_res_q;
	logic [AGE_WIDTH-1:0]  age_buf [MAX_WAYS];

	// Totals and result register.
	logic [TOTAL_W-1:0]     hits_q;
	logic [TOTAL_W-1:0]     misses_q;
	logic [TOTAL_W-1:0]     evictions_q;
	logic                   rsp_valid_q;
	logic                   rsp_hit_q;
	logic                   rsp_evicted_q;
	logic [WAY_FIELD_W-1:0] rsp_way_q;
	logic [TOTAL_W-1:0]     rsp_hits_q;
	logic [TOTAL_W-1:0]     rsp_misses_q;
	logic [TOTAL_W-1:0]     rsp_evictions_q;
	logic                   rsp_last_q;

	// Address split and clamped configuration.
	logic [SET_BITS_W-1:0] sb_c;
	logic [CNT_W-1:0]      ways_c;
	logic [SET_W-1:0]      set_c;
	logic [SHIFT_W-1:0]    shift_c;
	logic [ADDR_WIDTH-1:0] tag_c;
	logic [LINE_W-1:0]     base_c;

	// Memory ports and shared line address.
	logic [WAY_W-1:0]      way_sel;
	logic [LINE_W-1:0]     line_addr;
	logic                  valid_we;
	logic [SET_W-1:0]      valid_waddr;
	logic [MAX_WAYS-1:0]   valid_wdata;
	logic [MAX_WAYS-1:0]   valid_rdata;
	logic                  tag_we;
	logic [ADDR_WIDTH-1:0] tag_rdata;
	logic                  age_we;
	logic [AGE_WIDTH-1:0]  age_wdata;
	logic [AGE_WIDTH-1:0]  age_rdata;
	logic [WAY_W-1:0]      proc_w;
	logic [WAY_W-1:0]      age_w;

	scan_ctl_t        scan_ctl;
	scan_res_t        scan_res;
	logic [WAY_W-1:0] scan_way;

	logic accept;
	logic rsp_free;
	logic more_pass;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign more_pass = (op_q == OP_MODIFY) && !second_q;

	// Clamp the configuration to the built sizes.
	always_comb begin
		sb_c = (32'(set_bits_q) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_q;
		if (ways_in_use_q == '0) begin
			ways_c = CNT_W'(1);
		end else if (32'(ways_in_use_q) > MAX_WAYS) begin
			ways_c = CNT_W'(MAX_WAYS);
		end else begin
			ways_c = CNT_W'(ways_in_use_q);
		end
	end

	// Set index and tag of the held address.
	always_comb begin
		set_c   = SET_W'(addr_q >> block_bits_q) & ~({SET_W{1'b1}} << sb_c);
		shift_c = SHIFT_W'(sb_c) + SHIFT_W'(block_bits_q);
		tag_c   = (32'(shift_c) >= ADDR_WIDTH) ? '0 : (addr_q >> shift_c);
		base_c  = LINE_W'(set_c) * WAYS_LINE;
	end

	// One line address adder serves every tag and age access.
	assign way_sel   = (state_q == ST_DECIDE) ? scan_way : WAY_W'(cnt_q);
	assign line_addr = base_q + LINE_W'(way_sel);
	assign proc_w    = WAY_W'(cnt_q - 1'b1);
	assign age_w     = WAY_W'(cnt_q);

	// Valid rows: cleared after reset, a bit set on each fill.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			valid_we    = 1'b1;
			valid_waddr = clr_cnt_q;
			valid_wdata = '0;
		end else begin
			valid_we    = (state_q == ST_DECIDE) && !scan_res.hit;
			valid_waddr = set_q;
			valid_wdata = valid_rdata | (MAX_WAYS'(1) << scan_way);
		end
	end

	assign tag_we = (state_q == ST_DECIDE) && !scan_res.hit;

	// Age writeback: kept way to zero, other valid ways up one (saturating).
	always_comb begin
		age_we    = 1'b0;
		age_wdata = '0;
		if (state_q == ST_AGE) begin
			if (age_w == keep_q) begin
				age_we = 1'b1;
			end else if (vrow_q[age_w] && (age_buf[age_w] != AGE_MAX)) begin
				age_we    = 1'b1;
				age_wdata = age_buf[age_w] + 1'b1;
			end
		end
	end

	slacm_ram #(.WIDTH(MAX_WAYS), .DEPTH(NUM_SETS)) u_valid_ram (
		.clk   (clk),
		.we    (valid_we),
		.waddr (valid_waddr),
		.wdata (valid_wdata),
		.raddr (set_c),
		.rdata (valid_rdata)
	);

	slacm_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(NUM_LINES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (line_addr),
		.wdata (tag_q),
		.raddr (line_addr),
		.rdata (tag_rdata)
	);

	slacm_ram #(.WIDTH(AGE_WIDTH), .DEPTH(NUM_LINES)) u_age_ram (
		.clk   (clk),
		.we    (age_we),
		.waddr (line_addr),
		.wdata (age_wdata),
		.raddr (line_addr),
		.rdata (age_rdata)
	);

	// Scan control: read data for a way returns the cycle after its address.
	assign scan_ctl.start      = (state_q == ST_CALC);
	assign scan_ctl.step       = (state_q == ST_SCAN) && (cnt_q != '0);
	assign scan_ctl.line_valid = valid_rdata[proc_w];

	slacm_scan #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.AGE_WIDTH  (AGE_WIDTH),
		.MAX_WAYS   (MAX_WAYS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.way      (proc_w),
		.want_tag (tag_q),
		.line_tag (tag_rdata),
		.line_age (age_rdata),
		.res      (scan_res),
		.chosen   (scan_way)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= '0;
			block_bits_q  <= '0;
			ways_in_use_q <= WAYS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SET_BITS:   set_bits_q    <= cfg_wdata[SET_BITS_W-1:0];
				CFG_BLOCK_BITS: block_bits_q  <= cfg_wdata[BLOCK_BITS_W-1:0];
				CFG_WAYS:       ways_in_use_q <= cfg_wdata[WAYS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Item and access payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			addr_q <= req.address;
		end
		if (state_q == ST_CALC) begin
			set_q  <= set_c;
			tag_q  <= tag_c;
			base_q <= base_c;
			ways_q <= ways_c;
		end
		if (scan_ctl.step) begin
			age_buf[proc_w] <= age_rdata;
		end
	end

	// Sequencer, totals and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			second_q        <= 1'b0;
			cnt_q           <= '0;
			clr_cnt_q       <= '0;
			keep_q          <= '0;
			vrow_q          <= '0;
			hit_res_q       <= 1'b0;
			evict_res_q     <= 1'b0;
			hits_q          <= '0;
			misses_q        <= '0;
			evictions_q     <= '0;
			rsp_valid_q     <= 1'b0;
			rsp_hit_q       <= 1'b0;
			rsp_evicted_q   <= 1'b0;
			rsp_way_q       <= '0;
			rsp_hits_q      <= '0;
			rsp_misses_q    <= '0;
			rsp_evictions_q <= '0;
			rsp_last_q      <= 1'b0;
		end else begin
			// A loaded result stays valid until the sink takes it.
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == LAST_SET) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (req.op != OP_UNUSED)) begin
						second_q <= 1'b0;
						state_q  <= ST_CALC;
					end
				end
				ST_CALC: begin
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ways_q) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					keep_q      <= scan_way;
					vrow_q      <= valid_rdata;
					hit_res_q   <= scan_res.hit;
					evict_res_q <= !scan_res.hit && !scan_res.have_invalid;
					if (scan_res.hit) begin
						hits_q <= sat_inc(hits_q);
					end else begin
						misses_q <= sat_inc(misses_q);
						if (!scan_res.have_invalid) begin
							evictions_q <= sat_inc(evictions_q);
						end
					end
					cnt_q   <= '0;
					state_q <= ST_AGE;
				end
				ST_AGE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ways_q - 1'b1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_hit_q       <= hit_res_q;
						rsp_evicted_q   <= evict_res_q;
						rsp_way_q       <= WAY_FIELD_W'(keep_q);
						rsp_hits_q      <= hits_q;
						rsp_misses_q    <= misses_q;
						rsp_evictions_q <= evictions_q;
						rsp_last_q      <= !more_pass;
						if (more_pass) begin
							second_q <= 1'b1;
							state_q  <= ST_CALC;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.hit            = rsp_hit_q;
	assign rsp.evicted        = rsp_evicted_q;
	assign rsp.way            = rsp_way_q;
	assign rsp.hit_total      = rsp_hits_q;
	assign rsp.miss_total     = rsp_misses_q;
	assign rsp.eviction_total = rsp_evictions_q;
	assign rsp.last           = rsp_last_q;

`ifndef ASSERT_OFF
	// Age writes stay inside the ways in use of the current set.
	a_age_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		age_we |-> (cnt_q < ways_q))
		else $error("age write outside the ways in use");

	// Every eviction is also a miss.
	a_evict_le_miss: assert property (@(posedge clk) disable iff (!arst_n)
		evictions_q <= misses_q)
		else $error("eviction total above miss total");

	// A result is either a hit or an eviction, never both.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_hit_q && rsp_evicted_q))
		else $error("result marked as hit and eviction");

	// A new result only comes from the final sequencer step.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the final step");
`endif

endmodule

`default_nettype wire
